### rtl/olids_pkg.sv
// Package for the ordered list unit: sizes, opcodes, status codes and types.
// Used by the interfaces, the list cell and the top level. No dependencies.
`default_nettype none
package olids_pkg;

    localparam int DEPTH      = 16;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int OP_W       = 2;
    localparam int VAL_W      = 32;
    localparam int POS_W      = 8;
    localparam int ST_W       = 3;
    localparam int ITEM_POS_W = 5;
    localparam int CMP_W      = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

    localparam logic [OP_W-1:0] OP_INSERT  = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE  = 2'd1;
    localparam logic [OP_W-1:0] OP_SEARCH  = 2'd2;
    localparam logic [OP_W-1:0] OP_DISPLAY = 2'd3;

    localparam logic [ST_W-1:0] ST_OK      = 3'd0;
    localparam logic [ST_W-1:0] ST_BADPOS  = 3'd1;
    localparam logic [ST_W-1:0] ST_EMPTY   = 3'd2;
    localparam logic [ST_W-1:0] ST_MISSING = 3'd3;
    localparam logic [ST_W-1:0] ST_FULL    = 3'd4;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INS,
        CELL_DEL
    } t_cell_op;

    typedef struct packed {
        t_cell_op          op;
        logic [IDX_W-1:0]  pos_m1;
    } t_cell_ctl;

endpackage
`default_nettype wire

### rtl/olids_in_if.sv
// Input channel of the ordered list unit: valid/ready plus one request item.
// Depends on olids_pkg.
`default_nettype none
interface olids_in_if;
    logic                                  valid;
    logic                                  ready;
    logic [olids_pkg::OP_W-1:0]            opcode;
    logic signed [olids_pkg::VAL_W-1:0]    value;
    logic [olids_pkg::POS_W-1:0]           position;

    modport source (output valid, output opcode, output value, output position, input ready);
    modport sink   (input valid, input opcode, input value, input position, output ready);
endinterface
`default_nettype wire

### rtl/olids_out_if.sv
// Output channel of the ordered list unit: valid/ready plus one result item.
// Depends on olids_pkg.
`default_nettype none
interface olids_out_if;
    logic                                  valid;
    logic                                  ready;
    logic [olids_pkg::ST_W-1:0]            status;
    logic signed [olids_pkg::VAL_W-1:0]    item_value;
    logic [olids_pkg::ITEM_POS_W-1:0]      item_position;
    logic                                  backward;
    logic                                  last;

    modport source (output valid, output status, output item_value, output item_position,
                    output backward, output last, input ready);
    modport sink   (input valid, input status, input item_value, input item_position,
                    input backward, input last, output ready);
endinterface
`default_nettype wire

### rtl/olids_cell.sv
// One cell of the list chain: holds one entry, shifts with its neighbors on
// insert and delete, and compares its entry against the search key.
// Depends on olids_pkg.
`default_nettype none
module olids_cell (
    input  wire logic                                i_clk,
    input  wire logic [olids_pkg::IDX_W-1:0]         i_idx,
    input  wire olids_pkg::t_cell_ctl                i_ctl,
    input  wire logic signed [olids_pkg::VAL_W-1:0]  i_new,
    input  wire logic signed [olids_pkg::VAL_W-1:0]  i_left,
    input  wire logic signed [olids_pkg::VAL_W-1:0]  i_right,
    input  wire logic signed [olids_pkg::VAL_W-1:0]  i_key,
    output logic signed [olids_pkg::VAL_W-1:0]       o_data,
    output logic                                     o_match
);

    logic signed [olids_pkg::VAL_W-1:0] r_data;
    logic signed [olids_pkg::VAL_W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        case (i_ctl.op)
            olids_pkg::CELL_INS: begin
                if (i_idx == i_ctl.pos_m1) begin
                    n_data = i_new;
                end else if (i_idx > i_ctl.pos_m1) begin
                    n_data = i_left;
                end
            end
            olids_pkg::CELL_DEL: begin
                if (i_idx >= i_ctl.pos_m1) begin
                    n_data = i_right;
                end
            end
            default: n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data  = r_data;
    assign o_match = (r_data == i_key);

endmodule
`default_nettype wire

### rtl/ordered_list_insert_delete_search_unit.sv
// Ordered list of up to DEPTH (16) signed 32-bit values with positional
// insert and delete, search by value and a two-way display.
//
// Requests arrive on i_in (opcode, value, position) and results leave on
// o_out (status, item_value, item_position, backward, last); both channels
// move an item when valid and ready are high at a rising edge.
// Entries live in a chain of cells; an insert or delete shifts the cells
// from the given position on with their neighbors, and a search compares
// all cells at once followed by a priority pick of the lowest matching
// position. For insert, delete and search the result item is registered
// at the edge that accepts the request and shows on o_out the next cycle.
// A display streams 2*count result items, one per cycle while the receiver
// takes them; the first is registered from the display state, so it shows
// later than an edit result. A new request is taken only when no display
// is streaming and the output register is empty or is being drained in the
// same cycle, so the rate is one request per cycle for edits and searches.
// When the receiver stalls, the pending result holds and the input stalls.
// Synchronous reset empties the list and drops any pending result.
`default_nettype none
module ordered_list_insert_delete_search_unit (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    olids_in_if.sink   i_in,
    olids_out_if.source o_out
);

    localparam int D  = olids_pkg::DEPTH;
    localparam int IW = olids_pkg::IDX_W;
    localparam int CW = olids_pkg::CNT_W;
    localparam int MW = olids_pkg::CMP_W;
    localparam int VW = olids_pkg::VAL_W;
    localparam int PW = olids_pkg::ITEM_POS_W;
    localparam int SW = olids_pkg::ST_W;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_DISP = 2'b10
    } t_state;

    t_state                 r_state, n_state;
    logic [CW-1:0]          r_count, n_count;
    logic [IW-1:0]          r_idx, n_idx;
    logic                   r_back, n_back;

    logic                   r_out_valid, n_out_valid;
    logic [SW-1:0]          r_status, n_status;
    logic signed [VW-1:0]   r_value, n_value;
    logic [PW-1:0]          r_pos, n_pos;
    logic                   r_obk, n_obk;
    logic                   r_last, n_last;

    olids_pkg::t_cell_ctl   w_ctl;
    logic signed [VW-1:0]   w_data [D];
    logic [D-1:0]           w_match;
    logic                   w_slot;
    logic                   w_accept;
    logic                   w_found;
    logic [IW-1:0]          w_fidx;
    logic [MW-1:0]          w_pos_ext;
    logic [MW-1:0]          w_cnt_ext;

    genvar g;
    generate
        for (g = 0; g < D; g++) begin : g_cell
            logic signed [VW-1:0] w_left;
            logic signed [VW-1:0] w_right;
            if (g == 0) begin : g_first
                assign w_left = '0;
            end else begin : g_mid_l
                assign w_left = w_data[g-1];
            end
            if (g == D - 1) begin : g_last
                assign w_right = '0;
            end else begin : g_mid_r
                assign w_right = w_data[g+1];
            end
            olids_cell u_cell (
                .i_clk   (i_clk),
                .i_idx   (IW'(g)),
                .i_ctl   (w_ctl),
                .i_new   (i_in.value),
                .i_left  (w_left),
                .i_right (w_right),
                .i_key   (i_in.value),
                .o_data  (w_data[g]),
                .o_match (w_match[g])
            );
        end
    endgenerate

    assign w_slot    = !r_out_valid || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE) && w_slot;
    assign w_accept  = i_in.valid && i_in.ready;
    assign w_pos_ext = MW'(i_in.position);
    assign w_cnt_ext = MW'(r_count);

    // Lowest occupied cell that holds the key.
    always_comb begin
        w_found = 1'b0;
        w_fidx  = '0;
        for (int i = D - 1; i >= 0; i--) begin
            if (w_match[i] && (CW'(i) < r_count)) begin
                w_found = 1'b1;
                w_fidx  = IW'(i);
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_back      = r_back;
        n_out_valid = r_out_valid && !o_out.ready;
        n_status    = r_status;
        n_value     = r_value;
        n_pos       = r_pos;
        n_obk       = r_obk;
        n_last      = r_last;
        w_ctl.op    = olids_pkg::CELL_HOLD;
        w_ctl.pos_m1 = IW'(i_in.position - 8'd1);

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_out_valid = 1'b1;
                    n_status    = olids_pkg::ST_OK;
                    n_value     = '0;
                    n_pos       = '0;
                    n_obk       = 1'b0;
                    n_last      = 1'b1;
                    case (i_in.opcode)
                        olids_pkg::OP_INSERT: begin
                            if (w_pos_ext == '0 || w_pos_ext > w_cnt_ext + MW'(1)) begin
                                n_status = olids_pkg::ST_BADPOS;
                            end else if (r_count == CW'(D)) begin
                                n_status = olids_pkg::ST_FULL;
                            end else begin
                                w_ctl.op = olids_pkg::CELL_INS;
                                n_count  = r_count + CW'(1);
                            end
                        end
                        olids_pkg::OP_DELETE: begin
                            if (w_pos_ext == '0 || w_pos_ext > w_cnt_ext) begin
                                n_status = olids_pkg::ST_BADPOS;
                            end else begin
                                w_ctl.op = olids_pkg::CELL_DEL;
                                n_count  = r_count - CW'(1);
                            end
                        end
                        olids_pkg::OP_SEARCH: begin
                            if (r_count == '0) begin
                                n_status = olids_pkg::ST_EMPTY;
                            end else if (w_found) begin
                                n_value = i_in.value;
                                n_pos   = PW'(w_fidx) + PW'(1);
                            end else begin
                                n_status = olids_pkg::ST_MISSING;
                            end
                        end
                        olids_pkg::OP_DISPLAY: begin
                            if (r_count == '0) begin
                                n_status = olids_pkg::ST_EMPTY;
                            end else begin
                                // The stream starts next cycle from the front.
                                n_out_valid = 1'b0;
                                n_state     = S_DISP;
                                n_idx       = '0;
                                n_back      = 1'b0;
                            end
                        end
                        default: n_status = olids_pkg::ST_OK;
                    endcase
                end
            end
            S_DISP: begin
                if (w_slot) begin
                    n_out_valid = 1'b1;
                    n_status    = olids_pkg::ST_OK;
                    n_value     = w_data[r_idx];
                    n_pos       = PW'(r_idx) + PW'(1);
                    n_obk       = r_back;
                    n_last      = r_back && (r_idx == '0);
                    if (!r_back) begin
                        // The tail entry is sent once per direction.
                        if (r_idx == IW'(r_count - CW'(1))) begin
                            n_back = 1'b1;
                        end else begin
                            n_idx = r_idx + IW'(1);
                        end
                    end else if (r_idx == '0) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx = r_idx - IW'(1);
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
            r_back      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_idx       <= n_idx;
            r_back      <= n_back;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_value  <= n_value;
        r_pos    <= n_pos;
        r_obk    <= n_obk;
        r_last   <= n_last;
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.status        = r_status;
    assign o_out.item_value    = r_value;
    assign o_out.item_position = r_pos;
    assign o_out.backward      = r_obk;
    assign o_out.last          = r_last;

endmodule
`default_nettype wire
